### design/awf_pkg.sv
// Shared types, codes and helpers of the acceleration-to-position washout filter.
package awf_pkg;

  // Field widths
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 31;
  localparam int IDX_W   = 3;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 53;
  localparam int DIFF_W  = 35;
  localparam int PC_W    = 4;
  localparam int PROG_LEN = 12;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ACC_LIMIT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_PREV  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_PREV2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_IN    = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV_TSQ    = 3'd4;

  // Configuration reset values
  localparam logic [COEF_W-1:0] RST_ACC_LIMIT  = 31'd642253;
  localparam logic [COEF_W-1:0] RST_COEF_PREV  = 31'd1431752254;
  localparam logic [COEF_W-1:0] RST_COEF_PREV2 = 31'd361553568;
  localparam logic [COEF_W-1:0] RST_COEF_IN    = 31'd144621;
  localparam logic [DATA_W-1:0] RST_INV_TSQ    = 32'd163840000;

  // Multiplier operand A select
  localparam logic [1:0] A_CPREV  = 2'd0;
  localparam logic [1:0] A_CPREV2 = 2'd1;
  localparam logic [1:0] A_CIN    = 2'd2;
  localparam logic [1:0] A_INVTSQ = 2'd3;

  // Multiplier operand B select
  localparam logic [2:0] B_PPREV  = 3'd0;
  localparam logic [2:0] B_PPREV2 = 3'd1;
  localparam logic [2:0] B_ACC    = 3'd2;
  localparam logic [2:0] B_DHI    = 3'd3;
  localparam logic [2:0] B_DLO    = 3'd4;

  // Accumulator operations
  localparam logic [1:0] ACC_NOP  = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Product shift select
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_30 = 2'd2;

  // Special operations
  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_ACCEPT = 3'd1;
  localparam logic [2:0] OP_POS    = 3'd2;
  localparam logic [2:0] OP_DIFF   = 3'd3;
  localparam logic [2:0] OP_DONE   = 3'd4;

  // Jump conditions
  localparam logic [1:0] JC_NONE     = 2'd0;
  localparam logic [1:0] JC_NO_REQ   = 2'd1;
  localparam logic [1:0] JC_OUT_FREE = 2'd2;
  localparam logic [1:0] JC_ALWAYS   = 2'd3;

  typedef struct packed {
    logic [1:0]      a_sel;
    logic [2:0]      b_sel;
    logic [1:0]      acc_op;
    logic [1:0]      sh_sel;
    logic [2:0]      op;
    logic [1:0]      jc;
    logic [PC_W-1:0] jt;
  } awf_ctrl_t;

  typedef struct packed {
    logic in_req;
    logic out_free;
  } awf_stat_t;

  typedef struct packed {
    logic [COEF_W-1:0] acc_limit;
    logic [COEF_W-1:0] coef_prev;
    logic [COEF_W-1:0] coef_prev2;
    logic [COEF_W-1:0] coef_in;
    logic [DATA_W-1:0] inv_tsq;
  } awf_coef_t;

  // Saturate a wide signed value to signed 32 bits
  function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[ACC_W-1:DATA_W-1];
    all_zero = ~|v[ACC_W-1:DATA_W-1];
    if (all_one || all_zero) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

endpackage

### design/awf_if.sv
// Request channel interfaces: sample input, result output and register write port.
interface awf_in_if import awf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] acc_cmd;
  modport source (output valid, output acc_cmd, input ready);
  modport sink   (input valid, input acc_cmd, output ready);
endinterface

interface awf_out_if import awf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] position;
  logic [DATA_W-1:0] real_acc;
  logic              clamped;
  modport source (output valid, output position, output real_acc, output clamped,
                  input ready);
  modport sink   (input valid, input position, input real_acc, input clamped,
                  output ready);
endinterface

interface awf_cfg_if import awf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/accel_to_position_washout_filter.sv
// Top level of the acceleration-to-position washout filter.
//
// in_ch takes one commanded acceleration (signed Q16.16) per request; the
// block clamps it to +/- acc_limit and advances a second-order washout
// recurrence. out_ch returns one request per input: the new position, the
// acceleration implied by the position second difference, and a clamp flag.
// cfg_ch writes the five coefficient registers by index; write only while
// no request is in flight. Unknown indexes are dropped.
// One shared 33x33 multiplier is stepped by a 12-word microcode program:
// each request runs the program through its finish step before the next
// input is accepted.
// A finished result sits in an output register; the next input is accepted
// while it waits. If the receiver stalls, the finish step holds until the
// output register frees up, which stalls further inputs.
// Reset (rst_n low, synchronous) restores the default coefficients and
// clears both stored positions and the output valid.
module accel_to_position_washout_filter import awf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  awf_in_if.sink     in_ch,
  awf_out_if.source  out_ch,
  awf_cfg_if.sink    cfg_ch
);

  awf_coef_t coef;
  awf_ctrl_t ctrl;
  awf_stat_t stat;

  awf_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .coef   (coef)
  );

  awf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  awf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .coef   (coef),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### design/awf_cfg.sv
// Configuration register file of the washout filter.
module awf_cfg import awf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  awf_cfg_if.sink   cfg_ch,
  output awf_coef_t coef
);

  awf_coef_t coef_r;

  assign cfg_ch.ready = 1'b1;
  assign coef         = coef_r;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.acc_limit  <= RST_ACC_LIMIT;
      coef_r.coef_prev  <= RST_COEF_PREV;
      coef_r.coef_prev2 <= RST_COEF_PREV2;
      coef_r.coef_in    <= RST_COEF_IN;
      coef_r.inv_tsq    <= RST_INV_TSQ;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ACC_LIMIT:  coef_r.acc_limit  <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_PREV:  coef_r.coef_prev  <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_PREV2: coef_r.coef_prev2 <= cfg_ch.data[COEF_W-1:0];
        REG_COEF_IN:    coef_r.coef_in    <= cfg_ch.data[COEF_W-1:0];
        REG_INV_TSQ:    coef_r.inv_tsq    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

### design/awf_seq.sv
// Microcode sequencer: step counter, program ROM and conditional jumps.
module awf_seq import awf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  awf_stat_t stat,
  output awf_ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            jump;

  // Program: one control word per step
  function automatic awf_ctrl_t rom_word(input logic [PC_W-1:0] pc);
    awf_ctrl_t w;
    w        = '0;
    w.a_sel  = A_CPREV;
    w.b_sel  = B_PPREV;
    w.acc_op = ACC_NOP;
    w.sh_sel = SH_0;
    w.op     = OP_NOP;
    w.jc     = JC_NONE;
    case (pc)
      4'd0: begin
        w.op = OP_ACCEPT;  w.jc = JC_NO_REQ;  w.jt = 4'd0;
      end
      4'd1: begin
        w.a_sel = A_CPREV;  w.b_sel = B_PPREV;
      end
      4'd2: begin
        w.a_sel = A_CPREV2; w.b_sel = B_PPREV2; w.acc_op = ACC_LOAD; w.sh_sel = SH_30;
      end
      4'd3: begin
        w.a_sel = A_CIN;    w.b_sel = B_ACC;    w.acc_op = ACC_SUB;  w.sh_sel = SH_30;
      end
      4'd4: begin
        w.acc_op = ACC_ADD; w.sh_sel = SH_30;
      end
      4'd5: w.op = OP_POS;
      4'd6: w.op = OP_DIFF;
      4'd7: begin
        w.a_sel = A_INVTSQ; w.b_sel = B_DLO;
      end
      4'd8: begin
        w.a_sel = A_INVTSQ; w.b_sel = B_DHI;  w.acc_op = ACC_LOAD; w.sh_sel = SH_16;
      end
      4'd9: begin
        w.acc_op = ACC_ADD; w.sh_sel = SH_0;
      end
      4'd10: begin
        w.op = OP_DONE;    w.jc = JC_OUT_FREE; w.jt = 4'd0;
      end
      4'd11: begin
        w.jc = JC_ALWAYS;  w.jt = 4'd10;
      end
      default: begin
        w.jc = JC_ALWAYS;  w.jt = 4'd0;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom_word(pc_r);

  // Resolve the jump condition
  always_comb begin
    unique case (ctrl.jc)
      JC_NONE:     jump = 1'b0;
      JC_NO_REQ:   jump = !stat.in_req;
      JC_OUT_FREE: jump = stat.out_free;
      JC_ALWAYS:   jump = 1'b1;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.jt : pc_r + 4'd1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r < PROG_LEN[PC_W-1:0])
    else $error("step counter left the program");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == 4'd0 && stat.in_req) |=> pc_r == 4'd1)
    else $error("accepted request did not start the program");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == 4'd10 && !stat.out_free) |=> pc_r == 4'd11)
    else $error("finish step did not hold for a stalled output");

endmodule

### design/awf_dp.sv
// Datapath: clamp, shared multiplier, accumulator, filter state and output register.
module awf_dp import awf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  awf_ctrl_t  ctrl,
  input  awf_coef_t  coef,
  output awf_stat_t  stat,
  awf_in_if.sink     in_ch,
  awf_out_if.source  out_ch
);

  logic [DATA_W-1:0]        acc_r;      // clamped command
  logic                     clip_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         sum_r;
  logic [DATA_W-1:0]        x_r;
  logic [DIFF_W-1:0]        d_r;
  logic [DATA_W-1:0]        pp_r;
  logic [DATA_W-1:0]        pp2_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_pos_r;
  logic [DATA_W-1:0]        out_ra_r;
  logic                     out_clip_r;

  logic signed [DATA_W:0]   cmd_ext;
  logic signed [DATA_W:0]   lim_ext;
  logic signed [DATA_W:0]   neg_lim;
  logic                     over_hi;
  logic                     over_lo;
  logic [DATA_W-1:0]        acc_nxt;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_sh;
  logic [ACC_W-1:0]         term;
  logic [DIFF_W-1:0]        d_nxt;
  logic                     accept;
  logic                     done_fire;
  logic                     out_free;

  assign out_free      = !out_valid_r || out_ch.ready;
  assign stat.in_req   = in_ch.valid;
  assign stat.out_free = out_free;
  assign in_ch.ready   = (ctrl.op == OP_ACCEPT);
  assign accept        = in_ch.valid && (ctrl.op == OP_ACCEPT);
  assign done_fire     = (ctrl.op == OP_DONE) && out_free;

  // Clamp the command to the signed limit
  always_comb begin
    cmd_ext = $signed({in_ch.acc_cmd[DATA_W-1], in_ch.acc_cmd});
    lim_ext = $signed({2'b00, coef.acc_limit});
    neg_lim = -lim_ext;
    over_hi = cmd_ext > lim_ext;
    over_lo = cmd_ext < neg_lim;
    if (over_hi) begin
      acc_nxt = lim_ext[DATA_W-1:0];
    end else if (over_lo) begin
      acc_nxt = neg_lim[DATA_W-1:0];
    end else begin
      acc_nxt = in_ch.acc_cmd;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (ctrl.a_sel)
      A_CPREV:  mul_a = $signed({2'b00, coef.coef_prev});
      A_CPREV2: mul_a = $signed({2'b00, coef.coef_prev2});
      A_CIN:    mul_a = $signed({2'b00, coef.coef_in});
      A_INVTSQ: mul_a = $signed({1'b0, coef.inv_tsq});
      default:  mul_a = '0;
    endcase
    unique case (ctrl.b_sel)
      B_PPREV:  mul_b = $signed({pp_r[DATA_W-1], pp_r});
      B_PPREV2: mul_b = $signed({pp2_r[DATA_W-1], pp2_r});
      B_ACC:    mul_b = $signed({acc_r[DATA_W-1], acc_r});
      B_DHI:    mul_b = $signed({{14{d_r[DIFF_W-1]}}, d_r[DIFF_W-1:16]});
      B_DLO:    mul_b = $signed({17'd0, d_r[15:0]});
      default:  mul_b = '0;
    endcase
  end

  // Floor-shift the registered product
  always_comb begin
    unique case (ctrl.sh_sel)
      SH_0:    prod_sh = prod_r;
      SH_16:   prod_sh = prod_r >>> 16;
      SH_30:   prod_sh = prod_r >>> 30;
      default: prod_sh = prod_r;
    endcase
    term  = prod_sh[ACC_W-1:0];
    d_nxt = {{3{x_r[DATA_W-1]}}, x_r} - {{2{pp_r[DATA_W-1]}}, pp_r, 1'b0}
          + {{3{pp2_r[DATA_W-1]}}, pp2_r};
  end

  // Multiply, accumulate and hold intermediate results
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (ctrl.acc_op)
      ACC_NOP:  sum_r <= sum_r;
      ACC_LOAD: sum_r <= term;
      ACC_ADD:  sum_r <= sum_r + term;
      ACC_SUB:  sum_r <= sum_r - term;
      default:  sum_r <= sum_r;
    endcase
    if (accept) begin
      acc_r  <= acc_nxt;
      clip_r <= over_hi || over_lo;
    end
    if (ctrl.op == OP_POS) begin
      x_r <= sat32(sum_r);
    end
    if (ctrl.op == OP_DIFF) begin
      d_r <= d_nxt;
    end
    if (done_fire) begin
      out_pos_r  <= x_r;
      out_ra_r   <= sat32(sum_r);
      out_clip_r <= clip_r;
    end
  end

  // Shift the filter state and manage the output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r        <= '0;
      pp2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (done_fire) begin
        pp2_r       <= pp_r;
        pp_r        <= x_r;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;
  assign out_ch.real_acc = out_ra_r;
  assign out_ch.clamped  = out_clip_r;

  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_POS) |->
      ($signed({acc_r[DATA_W-1], acc_r}) <= $signed({2'b00, coef.acc_limit}) &&
       $signed({acc_r[DATA_W-1], acc_r}) >= -$signed({2'b00, coef.acc_limit})))
    else $error("clamped command exceeds the limit");

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> out_valid_r && out_pos_r == $past(x_r))
    else $error("finished request not presented");

  a_state_shift: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (pp_r == $past(x_r) && pp2_r == $past(pp_r)))
    else $error("filter state not advanced");

endmodule

### test/washout_checker.sv
// Checker for the washout filter: tracks the coefficient registers, predicts each result and compares.
`timescale 1ns / 1ps

module washout_checker import awf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  awf_in_if    in_ch,
  awf_out_if   out_ch,
  awf_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [DATA_W-1:0] position;
    logic [DATA_W-1:0] real_acc;
    logic              clamped;
  } washout_result_t;

  // Predictor copy of the coefficient registers and the position history
  logic [COEF_W-1:0] acc_limit;
  logic [COEF_W-1:0] coef_prev;
  logic [COEF_W-1:0] coef_prev2;
  logic [COEF_W-1:0] coef_in;
  logic [DATA_W-1:0] inv_tsq;
  longint            pos_last;
  longint            pos_last2;

  washout_result_t   pending_results[$];
  washout_result_t   want;

  task automatic report_error(input string msg);
    if (fail_count < 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  // Clip a wide signed value to the signed 32-bit range
  function automatic logic [DATA_W-1:0] clip32(input logic signed [99:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic void write_coef(input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] data);
    case (idx)
      REG_ACC_LIMIT:  acc_limit  = data[COEF_W-1:0];
      REG_COEF_PREV:  coef_prev  = data[COEF_W-1:0];
      REG_COEF_PREV2: coef_prev2 = data[COEF_W-1:0];
      REG_COEF_IN:    coef_in    = data[COEF_W-1:0];
      REG_INV_TSQ:    inv_tsq    = data;
      default: ;
    endcase
  endfunction

  // Clamp the command, advance the recurrence and derive the implied acceleration
  function automatic washout_result_t advance_filter(input logic [DATA_W-1:0] cmd);
    longint              lim;
    longint              acc;
    longint              sum;
    longint              pos;
    longint              diff;
    logic signed [99:0]  scaled;
    washout_result_t     r;
    lim       = longint'(acc_limit);
    acc       = longint'($signed(cmd));
    r.clamped = 1'b0;
    if (acc > lim) begin
      acc       = lim;
      r.clamped = 1'b1;
    end else if (acc < -lim) begin
      acc       = -lim;
      r.clamped = 1'b1;
    end
    // Floor shift of each Q1.30 x Q16.16 product, then an exact sum
    sum = ((longint'(coef_prev) * pos_last) >>> 30)
        - ((longint'(coef_prev2) * pos_last2) >>> 30)
        + ((longint'(coef_in) * acc) >>> 30);
    pos  = longint'($signed(clip32(100'(sum))));
    diff = pos - 2 * pos_last + pos_last2;
    scaled = 100'(diff) * 100'(longint'(inv_tsq));
    r.position = pos[DATA_W-1:0];
    r.real_acc = clip32(scaled >>> 16);
    pos_last2  = pos_last;
    pos_last   = pos;
    return r;
  endfunction

  // Watch the three channels; writes and inputs are folded in before results are checked
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_limit  = RST_ACC_LIMIT;
      coef_prev  = RST_COEF_PREV;
      coef_prev2 = RST_COEF_PREV2;
      coef_in    = RST_COEF_IN;
      inv_tsq    = RST_INV_TSQ;
      pos_last   = 0;
      pos_last2  = 0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        write_coef(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        pending_results.push_back(advance_filter(in_ch.acc_cmd));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_error($sformatf("result with no request pending: position %h",
                                 out_ch.position));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.position !== want.position) begin
            report_error($sformatf("position %h, expected %h", out_ch.position,
                                   want.position));
          end
          if (out_ch.real_acc !== want.real_acc) begin
            report_error($sformatf("real_acc %h, expected %h", out_ch.real_acc,
                                   want.real_acc));
          end
          if (out_ch.clamped !== want.clamped) begin
            report_error($sformatf("clamped %b, expected %b", out_ch.clamped,
                                   want.clamped));
          end
        end
      end
    end
    pending_count <= pending_results.size();
  end

endmodule

### test/accel_to_position_washout_filter_tb.sv
// Stimulus and verdict for the washout filter: directed corner cases, then phases of random commands.
`timescale 1ns / 1ps

module accel_to_position_washout_filter_tb import awf_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;

  awf_in_if  in_ch();
  awf_out_if out_ch();
  awf_cfg_if cfg_ch();

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int tx_mode = 0;
  int rx_mode = 0;
  logic [COEF_W-1:0] cur_limit = RST_ACC_LIMIT;
  longint motion_cmd = 0;

  accel_to_position_washout_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  washout_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length per request: none, full range, or short
  function automatic int pick_delay(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return $urandom_range(0, 2);
    endcase
  endfunction

  task automatic send_cmd(input logic [DATA_W-1:0] cmd);
    int gap;
    gap = pick_delay(tx_mode);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.acc_cmd <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    if (idx == REG_ACC_LIMIT) begin
      cur_limit = data[COEF_W-1:0];
    end
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic cfg_idle();
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_defaults();
    write_reg(REG_ACC_LIMIT,  {1'b0, RST_ACC_LIMIT});
    write_reg(REG_COEF_PREV,  {1'b0, RST_COEF_PREV});
    write_reg(REG_COEF_PREV2, {1'b0, RST_COEF_PREV2});
    write_reg(REG_COEF_IN,    {1'b0, RST_COEF_IN});
    write_reg(REG_INV_TSQ,    RST_INV_TSQ);
  endtask

  // Derive a consistent coefficient set from a random platform
  task automatic load_platform();
    real t, amax, xmax, vmax, k1, k2, d;
    logic [DATA_W-1:0] v;
    t    = 0.005 + 0.045 * $urandom_range(0, 1000) / 1000.0;
    amax = 1.0 + $urandom_range(0, 190) / 10.0;
    xmax = 0.1 + $urandom_range(0, 90) / 100.0;
    vmax = 0.05 + $urandom_range(0, 45) / 100.0;
    k1   = amax / xmax;
    k2   = amax / vmax;
    d    = 1.0 + k2 * t + k1 * t * t;
    v = DATA_W'(longint'(amax * 65536.0));
    write_reg(REG_ACC_LIMIT, v);
    v = DATA_W'(longint'((2.0 + k2 * t) / d * 1073741824.0));
    write_reg(REG_COEF_PREV, v);
    v = DATA_W'(longint'(1073741824.0 / d));
    write_reg(REG_COEF_PREV2, v);
    v = DATA_W'(longint'(t * t / d * 1073741824.0));
    write_reg(REG_COEF_IN, v);
    v = DATA_W'(longint'(65536.0 / (t * t)));
    write_reg(REG_INV_TSQ, v);
  endtask

  // Full 32-bit random data, upper bits included, plus a write to an unused index
  task automatic load_random();
    write_reg(REG_ACC_LIMIT,  $urandom);
    write_reg(REG_COEF_PREV,  $urandom);
    write_reg(REG_COEF_PREV2, $urandom);
    write_reg(REG_COEF_IN,    $urandom);
    write_reg(REG_INV_TSQ,    $urandom);
    write_reg(IDX_W'($urandom_range(REG_INV_TSQ + 1, 7)), $urandom);
  endtask

  task automatic load_uniform(input logic [DATA_W-1:0] v);
    write_reg(REG_ACC_LIMIT,  v);
    write_reg(REG_COEF_PREV,  v);
    write_reg(REG_COEF_PREV2, v);
    write_reg(REG_COEF_IN,    v);
    write_reg(REG_INV_TSQ,    v);
  endtask

  // Mostly smooth motion profiles, with edge values and noise mixed in
  function automatic logic [DATA_W-1:0] pick_cmd();
    longint lim;
    longint step;
    lim  = longint'(cur_limit);
    step = lim / 8 + 1;
    case ($urandom_range(0, 9))
      6: return $urandom;
      7: return DATA_W'((lim + longint'($urandom_range(0, 2)) - 1) *
                        ($urandom_range(0, 1) ? 1 : -1));
      8: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      9: return '0;
      default: begin
        motion_cmd = motion_cmd + longint'($urandom_range(0, int'(2 * step))) - step;
        if (motion_cmd > 2 * lim) motion_cmd = 2 * lim;
        if (motion_cmd < -2 * lim) motion_cmd = -2 * lim;
        if (motion_cmd > 64'sd2147483647) motion_cmd = 64'sd2147483647;
        if (motion_cmd < -64'sd2147483648) motion_cmd = -64'sd2147483648;
        return motion_cmd[DATA_W-1:0];
      end
    endcase
  endfunction

  // Result side: stall per request, switching between stall patterns
  initial begin
    int stall;
    int run;
    run = 0;
    @(posedge rst_n);
    forever begin
      if (run == 0) begin
        rx_mode = $urandom_range(0, 2);
        run     = 25;
      end
      run--;
      stall = pick_delay(rx_mode);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n_items;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.acc_cmd  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset coefficients: zero, field extremes and the clamp boundary
    send_cmd('0);
    send_cmd(32'h7fff_ffff);
    send_cmd(32'h8000_0000);
    send_cmd(DATA_W'(RST_ACC_LIMIT));
    send_cmd(-DATA_W'(RST_ACC_LIMIT));
    send_cmd(DATA_W'(RST_ACC_LIMIT) + 1);
    send_cmd(-DATA_W'(RST_ACC_LIMIT) - 1);
    send_cmd(32'd1);
    send_cmd(32'hffff_ffff);

    // Zero limit: any nonzero command is clamped to zero
    drain_results();
    write_reg(REG_ACC_LIMIT, '0);
    cfg_idle();
    send_cmd('0);
    send_cmd(32'd1);
    send_cmd(32'hffff_ffff);

    // Upper register bits dropped, and writes to unused indexes dropped
    drain_results();
    write_reg(REG_ACC_LIMIT, 32'h8000_0010);
    write_reg(IDX_W'(REG_INV_TSQ + 1), 32'hffff_ffff);
    write_reg(IDX_W'(7), 32'h0000_0001);
    cfg_idle();
    send_cmd(32'd16);
    send_cmd(32'd17);
    send_cmd(-32'sd17);

    // Overflow: position and implied acceleration both saturate
    drain_results();
    load_uniform(32'hffff_ffff);
    cfg_idle();
    repeat (3) send_cmd(32'h7fff_ffff);
    repeat (3) send_cmd(32'h8000_0000);

    // Random phases over several coefficient settings
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      case (ph % 4)
        0: load_defaults();
        1: load_platform();
        2: load_random();
        default: load_uniform(ph == 3 ? 32'hffff_ffff : 32'h0000_0000);
      endcase
      cfg_idle();
      motion_cmd = 0;
      n_items = (ph % 4 == 3) ? 60 : 270;
      for (int i = 0; i < n_items; i++) begin
        if (i % 32 == 0) begin
          tx_mode = $urandom_range(0, 2);
        end
        if ($urandom_range(0, 149) == 0) begin
          drain_results();
        end
        send_cmd(pick_cmd());
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
